// ===== src/sat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the section address translator.
// No dependencies; every other file imports this package.
package sat_pkg;

  localparam int SAT_MAX_SECTIONS = 16;
  localparam int ADDR_W = 32;
  localparam int CNT_CFG_W = 5;
  localparam int IDX_IN_W = 4;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    OUT_WRITTEN = 2'd0,
    OUT_IN_SECTION = 2'd1,
    OUT_PASS_THROUGH = 2'd2,
    OUT_UNMAPPED = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] raw;
  } entry_t;

endpackage

// ===== src/sat_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces with valid/ready handshake.
// Depends on sat_pkg for field widths and the outcome type.
interface sat_req_if import sat_pkg::*; ();
  logic valid;
  logic ready;
  logic func;
  logic [IDX_IN_W-1:0] entry_index;
  logic [ADDR_W-1:0] entry_start;
  logic [ADDR_W-1:0] entry_size;
  logic [ADDR_W-1:0] entry_raw_offset;
  logic [ADDR_W-1:0] relative_address;

  modport source(output valid, func, entry_index, entry_start, entry_size,
                 entry_raw_offset, relative_address, input ready);
  modport sink(input valid, func, entry_index, entry_start, entry_size,
               entry_raw_offset, relative_address, output ready);
endinterface

interface sat_rsp_if import sat_pkg::*; ();
  logic valid;
  logic ready;
  logic [ADDR_W-1:0] file_offset;
  outcome_t outcome;

  modport source(output valid, file_offset, outcome, input ready);
  modport sink(input valid, file_offset, outcome, output ready);
endinterface

// ===== src/sat_table.sv =====
`timescale 1ns / 1ps
// Section entry memory: one write port, one read port with registered data.
// Depends on sat_pkg for the entry type.
module sat_table import sat_pkg::*; #(
  parameter int DEPTH = SAT_MAX_SECTIONS,
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sat_engine.sv =====
`timescale 1ns / 1ps
// Sequencer and shared range-compare unit that scans the section table.
// Depends on sat_pkg, the channel interfaces and the sat_table ports.
module sat_engine import sat_pkg::*; #(
  parameter int MAX_SECTIONS = SAT_MAX_SECTIONS,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_CFG_W-1:0] section_count,
  sat_req_if.sink              req,
  sat_rsp_if.source            rsp,
  output logic                 tbl_we,
  output logic [IW-1:0]        tbl_waddr,
  output entry_t               tbl_wdata,
  output logic                 tbl_re,
  output logic [IW-1:0]        tbl_raddr,
  input  entry_t               tbl_rdata
);

  state_t state;
  state_t state_next;

  logic [CW-1:0] rd_ptr;
  logic pend;
  logic is_write;
  logic is_hit;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] raw;
  logic [ADDR_W-1:0] bound;

  logic [CW-1:0] count_sat;
  logic [ADDR_W-1:0] widx;
  logic accept;
  logic issue;
  logic load_out;
  logic [ADDR_W-1:0] range_end;
  logic hit;
  logic [ADDR_W-1:0] res_offset;
  outcome_t res_outcome;

  always_comb begin
    if ({{(ADDR_W-CNT_CFG_W){1'b0}}, section_count} > ADDR_W'(MAX_SECTIONS)) begin
      count_sat = CW'(MAX_SECTIONS);
    end else begin
      count_sat = CW'(section_count);
    end
  end

  assign widx = {{(ADDR_W-IDX_IN_W){1'b0}}, req.entry_index};
  assign range_end = tbl_rdata.start + tbl_rdata.size;
  assign hit = (addr >= tbl_rdata.start) && (addr < range_end);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.func == FUNC_WRITE) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend && hit) begin
          state_next = ST_DONE;
        end else if (!issue && !pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    issue = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: issue = (rd_ptr < count_sat);
      ST_DONE: load_out = !rsp.valid || rsp.ready;
      default: req.ready = 1'b0;
    endcase
  end

  assign accept = req.valid && req.ready;

  assign tbl_we = accept && (req.func == FUNC_WRITE) && (widx < ADDR_W'(MAX_SECTIONS));
  assign tbl_waddr = widx[IW-1:0];
  assign tbl_wdata = '{start: req.entry_start, size: req.entry_size,
                       raw: req.entry_raw_offset};
  assign tbl_re = issue;
  assign tbl_raddr = rd_ptr[IW-1:0];

  always_comb begin
    if (is_write) begin
      res_offset = '0;
      res_outcome = OUT_WRITTEN;
    end else if (is_hit) begin
      res_offset = raw + diff;
      res_outcome = OUT_IN_SECTION;
    end else if (addr < bound) begin
      res_offset = addr;
      res_outcome = OUT_PASS_THROUGH;
    end else begin
      res_offset = ALL_ONES;
      res_outcome = OUT_UNMAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      pend <= issue;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= req.relative_address;
      is_write <= (req.func == FUNC_WRITE);
      is_hit <= 1'b0;
      bound <= ALL_ONES;
      rd_ptr <= '0;
    end else begin
      if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (pend && (state == ST_SCAN)) begin
        diff <= addr - tbl_rdata.start;
        raw <= tbl_rdata.raw;
        is_hit <= hit;
        if ((tbl_rdata.raw != '0) && (tbl_rdata.raw < bound)) begin
          bound <= tbl_rdata.raw;
        end
      end
    end
    if (load_out) begin
      rsp.file_offset <= res_offset;
      rsp.outcome <= res_outcome;
    end
  end

endmodule

// ===== src/section_address_translator_top.sv =====
`timescale 1ns / 1ps
// Top level of the section address translator: count register, table, engine.
// Depends on sat_pkg, sat_if, sat_table and sat_engine.

// An entry write skips the table scan and its result goes to the output
// register. A translate reads one table entry per cycle through the single
// read port of the section table and checks it in the shared range-compare
// unit; the scan stops at the first matching entry or after the first n
// entries, where n is the section count capped at MAX_SECTIONS.
// The block takes a new request only when idle; a finished result waits in an
// output register, so the next request is still accepted, but its own result
// then holds the engine until that register frees.
module section_address_translator_top import sat_pkg::*; #(
  parameter int MAX_SECTIONS = SAT_MAX_SECTIONS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CNT_CFG_W-1:0] cfg_wr_data,
  sat_req_if.sink              req,
  sat_rsp_if.source            rsp
);

  localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);

  logic [CNT_CFG_W-1:0] section_count;
  logic tbl_we;
  logic [IW-1:0] tbl_waddr;
  entry_t tbl_wdata;
  logic tbl_re;
  logic [IW-1:0] tbl_raddr;
  entry_t tbl_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
    end else if (cfg_wr_en) begin
      section_count <= cfg_wr_data;
    end
  end

  sat_table #(
    .DEPTH(MAX_SECTIONS),
    .IW(IW)
  ) u_table (
    .clk(clk),
    .we(tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re(tbl_re),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  sat_engine #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .IW(IW),
    .CW(CW)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .section_count(section_count),
    .req(req),
    .rsp(rsp),
    .tbl_we(tbl_we),
    .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata),
    .tbl_re(tbl_re),
    .tbl_raddr(tbl_raddr),
    .tbl_rdata(tbl_rdata)
  );

endmodule

// ===== src/sat_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the section address translator, bound to the top.
// Depends on sat_pkg and section_address_translator_top.
module sat_checker import sat_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [ADDR_W-1:0] rsp_file_offset,
  input logic [1:0]        rsp_outcome
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_file_offset)
      && $stable(rsp_outcome))
    else $error("Stalled response changed.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request accepted while a previous one was in progress.");

  a_fixed_offsets: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_outcome != OUT_WRITTEN || rsp_file_offset == '0)
      && (rsp_outcome != OUT_UNMAPPED || rsp_file_offset == ALL_ONES))
    else $error("Write or unmapped response carries a wrong offset.");

  a_pass_through_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_outcome == OUT_PASS_THROUGH |-> rsp_file_offset != ALL_ONES)
    else $error("Pass-through response carries the all-ones offset.");

endmodule

bind section_address_translator_top sat_checker u_sat_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_file_offset(rsp.file_offset),
  .rsp_outcome(rsp.outcome)
);
